// ===== hdl/ppnd_pkg.sv =====
// Package: payload types and widths for the point-to-polygon distance block.
package ppnd_pkg;
  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;          // difference of two coordinates
  localparam int ProdW  = 2 * DiffW;           // one product
  localparam int DotW   = ProdW + 1;           // sum of two products, signed
  localparam int SqW    = 35;                  // squared distance
  localparam int DistW  = CoordW + 1;          // square root result
  localparam int QuotW  = DiffW;               // quotient magnitude bound

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] edge_start_x;
    logic signed [CoordW-1:0] edge_start_y;
    logic signed [CoordW-1:0] edge_end_x;
    logic signed [CoordW-1:0] edge_end_y;
    logic                     last_edge;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0]         min_distance;
    logic signed [CoordW-1:0] closest_x;
    logic signed [CoordW-1:0] closest_y;
  } out_item_t;

  // Control between sequencer and shared divide/root unit.
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } unit_cmd_t;
endpackage

// ===== hdl/ppnd_divsqrt.sv =====
// Shared iterative unit: restoring divide or bitwise integer square root.
module ppnd_divsqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ppnd_pkg::unit_cmd_t       cmd_i,
  input  logic [2*ppnd_pkg::SqW-1:0] num_i,   // dividend or radicand
  input  logic [ppnd_pkg::SqW-1:0]  den_i,
  output logic                      busy_o,
  output logic [2*ppnd_pkg::SqW-1:0] res_o
);
  localparam int W  = 2 * ppnd_pkg::SqW;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]      num_q, quo_q, rem_q;
  logic [ppnd_pkg::SqW-1:0] den_q;
  logic [CW-1:0]     cnt_q;
  logic              sqrt_q, busy_q;
  logic [W:0]        trial;
  logic [W-1:0]      rem_sh;

  // One quotient/root bit per cycle.
  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q[W-3:0], num_q[W-1:W-2]};
      trial  = {1'b0, rem_sh} - {1'b0, quo_q[W-3:0], 2'b01};
    end else begin
      rem_sh = {rem_q[W-2:0], num_q[W-1]};
      trial  = {1'b0, rem_sh} - {{(W-ppnd_pkg::SqW+1){1'b0}}, den_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      sqrt_q <= cmd_i.is_sqrt;
      num_q  <= num_i;
      den_q  <= den_i;
      quo_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= cmd_i.is_sqrt ? CW'(W / 2) : CW'(W);
    end else if (busy_q) begin
      num_q <= sqrt_q ? {num_q[W-3:0], 2'b00} : {num_q[W-2:0], 1'b0};
      rem_q <= trial[W] ? rem_sh : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ~trial[W]};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign res_o  = quo_q;
endmodule

// ===== hdl/point_polygon_nearest_distance.sv =====
// Top level: per-edge nearest point, running minimum, distance on last edge.
//
//  channel | signals                      | payload
//  input   | in_valid_i / in_ready_o      | ppnd_pkg::in_item_t
//  output  | out_valid_o / out_ready_i    | ppnd_pkg::out_item_t
//
// An edge clamped to a vertex skips the divides; a projected edge runs two
// divides (launch, 70 bit steps, collect) on one shared bit-serial unit, one
// for x and one for y.
// The last edge adds a 35-step square root on the same unit, its
// launch and collect states, and the output step.
// Reset clears the running minimum; a new edge is refused while busy, and the
// output step holds while the previous result still waits for its transfer.
module point_polygon_nearest_distance (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ppnd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppnd_pkg::out_item_t  out_data_o
);
  localparam int CW = ppnd_pkg::CoordW;
  localparam int DW = ppnd_pkg::DiffW;
  localparam int SW = ppnd_pkg::SqW;
  localparam int UW = 2 * SW;

  typedef enum logic [3:0] {
    S_IDLE, S_DOT1, S_DOT2, S_DOT3, S_DECIDE, S_DIVX, S_DIVY,
    S_DSQ1, S_DSQ2, S_CMP, S_SQRT, S_OUT
  } state_e;

  state_e state_q;
  ppnd_pkg::in_item_t item_q;
  logic signed [DW-1:0] vx_q, vy_q, wx_q, wy_q, cx_q, cy_q;
  logic signed [ppnd_pkg::DotW-1:0] c1_q, c3_q, acc_q;
  logic [SW-1:0] best_q, dsq_q;
  logic signed [CW-1:0] bx_q, by_q;
  logic have_q, wait_q;
  ppnd_pkg::out_item_t out_q;
  logic out_v_q;

  // Shared multiplier operands, one product per cycle.
  logic signed [DW-1:0] ma, mb;
  logic signed [ppnd_pkg::ProdW-1:0] prod;
  assign prod = ma * mb;

  ppnd_pkg::unit_cmd_t cmd;
  logic [UW-1:0] unum, ures;
  logic ubusy;
  logic [DW-1:0] vmag;

  ppnd_divsqrt u_unit (
    .clk_i, .rst_ni, .cmd_i(cmd), .num_i(unum),
    .den_i(c3_q[SW-1:0]), .busy_o(ubusy), .res_o(ures)
  );

  always_comb begin
    ma = vx_q; mb = wx_q;
    case (state_q)
      S_DOT1:  begin ma = vx_q; mb = wx_q; end
      S_DOT2:  begin ma = vy_q; mb = wy_q; end
      S_DOT3:  begin ma = vx_q; mb = vx_q; end
      S_DECIDE: begin ma = vy_q; mb = vy_q; end
      S_DSQ1:  begin ma = DW'(item_q.point_x) - cx_q; mb = ma; end
      S_DSQ2:  begin ma = DW'(item_q.point_y) - cy_q; mb = ma; end
      default: ;
    endcase
  end

  // Divide numerator |v component| * c1, root radicand the best squared distance.
  always_comb begin
    vmag = (state_q == S_DIVY) ? (vy_q[DW-1] ? -vy_q : vy_q)
                               : (vx_q[DW-1] ? -vx_q : vx_q);
    unum = UW'(vmag) * UW'(c1_q[SW-1:0]);
    if (state_q == S_SQRT) unum = UW'(best_q);
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      best_q  <= '1;
      bx_q    <= '0;
      by_q    <= '0;
      have_q  <= 1'b0;
      wait_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i && state_q != S_OUT) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) begin
          item_q <= in_data_i;
          vx_q <= DW'(in_data_i.edge_end_x) - DW'(in_data_i.edge_start_x);
          vy_q <= DW'(in_data_i.edge_end_y) - DW'(in_data_i.edge_start_y);
          wx_q <= DW'(in_data_i.point_x) - DW'(in_data_i.edge_start_x);
          wy_q <= DW'(in_data_i.point_y) - DW'(in_data_i.edge_start_y);
          state_q <= S_DOT1;
        end
        S_DOT1: begin acc_q <= ppnd_pkg::DotW'(prod); state_q <= S_DOT2; end
        S_DOT2: begin
          c1_q <= acc_q + ppnd_pkg::DotW'(prod);
          state_q <= S_DOT3;
        end
        S_DOT3: begin acc_q <= ppnd_pkg::DotW'(prod); state_q <= S_DECIDE; end
        S_DECIDE: begin
          // c2 = c3 - c1 exactly
          c3_q <= acc_q + ppnd_pkg::DotW'(prod);
          wait_q <= 1'b0;
          if (c1_q <= 0) begin
            cx_q <= DW'(item_q.edge_start_x); cy_q <= DW'(item_q.edge_start_y);
            state_q <= S_DSQ1;
          end else if (acc_q + ppnd_pkg::DotW'(prod) - c1_q <= 0) begin
            cx_q <= DW'(item_q.edge_end_x); cy_q <= DW'(item_q.edge_end_y);
            state_q <= S_DSQ1;
          end else state_q <= S_DIVX;
        end
        S_DIVX: if (!wait_q) wait_q <= 1'b1;
          else if (!ubusy) begin
            cx_q <= DW'(item_q.edge_start_x)
                  + (vx_q[DW-1] ? -DW'(ures) : DW'(ures));
            wait_q <= 1'b0; state_q <= S_DIVY;
          end
        S_DIVY: if (!wait_q) wait_q <= 1'b1;
          else if (!ubusy) begin
            cy_q <= DW'(item_q.edge_start_y)
                  + (vy_q[DW-1] ? -DW'(ures) : DW'(ures));
            wait_q <= 1'b0; state_q <= S_DSQ1;
          end
        S_DSQ1: begin dsq_q <= SW'(prod); state_q <= S_DSQ2; end
        S_DSQ2: begin dsq_q <= dsq_q + SW'(prod); state_q <= S_CMP; end
        S_CMP: begin
          if (!have_q || dsq_q < best_q) begin
            best_q <= dsq_q; bx_q <= cx_q[CW-1:0]; by_q <= cy_q[CW-1:0];
          end
          have_q <= 1'b1;
          wait_q <= 1'b0;
          state_q <= item_q.last_edge ? S_SQRT : S_IDLE;
        end
        S_SQRT: if (!wait_q) wait_q <= 1'b1;
          else if (!ubusy) state_q <= S_OUT;
        // Hold until the output register is free or drains this cycle
        S_OUT: if (!out_v_q || out_ready_i) begin
          out_q.min_distance <= ures[ppnd_pkg::DistW-1:0];
          out_q.closest_x <= bx_q;
          out_q.closest_y <= by_q;
          out_v_q <= 1'b1;
          best_q <= '1; bx_q <= '0; by_q <= '0; have_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Launch the shared unit on entry to each long operation.
  always_comb begin : launch
    cmd.start = 1'b0;
    cmd.is_sqrt = (state_q == S_SQRT);
    if ((state_q == S_DIVX || state_q == S_DIVY || state_q == S_SQRT) && !wait_q)
      cmd.start = 1'b1;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule

// ===== hdl/ppnd_checker.sv =====
// Checker: port-level properties of the distance block, bound to the top.
module ppnd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ppnd_pkg::out_item_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after transfer");
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result after reset");
endmodule

bind point_polygon_nearest_distance ppnd_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// ===== tb/point_polygon_nearest_distance_tb.sv =====
// Testbench: point-to-polygon nearest distance block, self-checking against a predictor.
module point_polygon_nearest_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  ppnd_pkg::in_item_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  ppnd_pkg::out_item_t  out_data_o;

  point_polygon_nearest_distance dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // Predictor state
  logic [ppnd_pkg::SqW-1:0] run_best_sq;
  logic signed [15:0] run_best_x, run_best_y;
  bit                run_have;
  ppnd_pkg::out_item_t distance_q[$];

  int errors = 0;
  int edges_sent = 0;
  int polygons_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint trunc_offset(longint comp, longint num, longint den);
    longint unsigned mag, q;
    mag = (comp < 0) ? -comp : comp;
    q = (mag * num) / den;
    return (comp < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Fold one edge into the running minimum; queue the distance on the last edge
  task automatic predict_edge(ppnd_pkg::in_item_t it);
    longint px, py, sx, sy, ex, ey, vx, vy, c1, c2, c3, cx, cy, dx, dy;
    logic [ppnd_pkg::SqW-1:0] dsq;
    ppnd_pkg::out_item_t r;
    px = it.point_x; py = it.point_y;
    sx = it.edge_start_x; sy = it.edge_start_y;
    ex = it.edge_end_x; ey = it.edge_end_y;
    vx = ex - sx; vy = ey - sy;
    c1 = vx * (px - sx) + vy * (py - sy);
    c2 = (sx - ex) * (px - ex) + (sy - ey) * (py - ey);
    c3 = vx * vx + vy * vy;
    if (c1 <= 0) begin
      cx = sx; cy = sy;
    end else if (c2 <= 0 || c3 <= 0) begin
      cx = ex; cy = ey;
    end else begin
      cx = sx + trunc_offset(vx, c1, c3);
      cy = sy + trunc_offset(vy, c1, c3);
    end
    dx = px - cx; dy = py - cy;
    dsq = ppnd_pkg::SqW'(dx * dx + dy * dy);
    if (!run_have || dsq < run_best_sq) begin
      run_best_sq = dsq;
      run_best_x = 16'(cx);
      run_best_y = 16'(cy);
    end
    run_have = 1'b1;
    if (it.last_edge) begin
      r.min_distance = ppnd_pkg::DistW'(int_sqrt(64'(run_best_sq)));
      r.closest_x = run_best_x;
      r.closest_y = run_best_y;
      distance_q = {distance_q, r};
      run_best_sq = '1; run_best_x = '0; run_best_y = '0; run_have = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one edge; hold valid and payload until the transfer
  task automatic send_edge(ppnd_pkg::in_item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_edge(it);
    edges_sent++;
  endtask

  // Randomize the receiver stall each cycle
  always @(posedge clk_i) begin
    if (rst_ni)
      out_ready_i <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (distance_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        ppnd_pkg::out_item_t want;
        want = distance_q.pop_front();
        if (out_data_o.min_distance !== want.min_distance)
          report_mismatch("min_distance", out_data_o.min_distance, want.min_distance);
        if (out_data_o.closest_x !== want.closest_x)
          report_mismatch("closest_x", out_data_o.closest_x, want.closest_x);
        if (out_data_o.closest_y !== want.closest_y)
          report_mismatch("closest_y", out_data_o.closest_y, want.closest_y);
        polygons_checked++;
      end
    end
  end

  function automatic ppnd_pkg::in_item_t make_edge(int px, int py, int sx, int sy,
                                                   int ex, int ey, bit last);
    ppnd_pkg::in_item_t it;
    it.point_x = 16'(px); it.point_y = 16'(py);
    it.edge_start_x = 16'(sx); it.edge_start_y = 16'(sy);
    it.edge_end_x = 16'(ex); it.edge_end_y = 16'(ey);
    it.last_edge = last;
    return it;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023)) - 16'd512;
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 255)) - 16'd128;
    endcase
  endfunction

  // Directed: clamp to start, clamp to end, projection, degenerate, extremes, ties
  task automatic test_directed();
    send_edge(make_edge(-256, 0, 0, 0, 512, 0, 1));
    send_edge(make_edge(768, 100, 0, 0, 512, 0, 1));
    send_edge(make_edge(100, 300, 0, 0, 512, 0, 1));
    send_edge(make_edge(77, -33, 10, 10, 10, 10, 1));
    send_edge(make_edge(3, 7, 0, 0, 1000, 333, 1));
    send_edge(make_edge(32767, 32767, -32768, -32768, -32768, -32768, 1));
    send_edge(make_edge(-32768, 32767, 32767, -32768, 32767, -32768, 1));
    send_edge(make_edge(0, 0, -32768, -32768, 32767, 32767, 1));
    send_edge(make_edge(-32768, -32768, 32767, -32768, -32768, 32767, 1));
    // square around the origin: equal distances, first edge wins
    send_edge(make_edge(0, 0, -256, -256, 256, -256, 0));
    send_edge(make_edge(0, 0, 256, -256, 256, 256, 0));
    send_edge(make_edge(0, 0, 256, 256, -256, 256, 0));
    send_edge(make_edge(0, 0, -256, 256, -256, -256, 1));
    // later edge strictly nearer
    send_edge(make_edge(0, 0, 1000, 1000, 2000, 1000, 0));
    send_edge(make_edge(0, 0, 5, -50, 5, 50, 0));
    send_edge(make_edge(0, 0, 900, 900, 900, 1200, 1));
    send_edge(make_edge(32767, -32768, 0, 0, 0, 0, 0));
    send_edge(make_edge(32767, -32768, 32767, -32768, 32767, -32768, 1));
  endtask

  // Random polygons, mostly a few edges sharing one query point
  task automatic test_random(int n_edges);
    ppnd_pkg::in_item_t it;
    int left;
    logic [15:0] px, py, sx, sy;
    left = 0;
    for (int i = 0; i < n_edges; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 6);
        px = rand_coord(); py = rand_coord();
        sx = rand_coord(); sy = rand_coord();
      end
      it.point_x = ($urandom_range(9) == 0) ? rand_coord() : px;
      it.point_y = ($urandom_range(9) == 0) ? rand_coord() : py;
      it.edge_start_x = sx; it.edge_start_y = sy;
      it.edge_end_x = ($urandom_range(15) == 0) ? sx : rand_coord();
      it.edge_end_y = ($urandom_range(15) == 0) ? sy : rand_coord();
      sx = it.edge_end_x; sy = it.edge_end_y;
      left--;
      it.last_edge = (left == 0) || (i == n_edges - 1);
      if (it.last_edge) left = 0;
      send_edge(it);
    end
  endtask

  // Drop valid after the last transfer, then wait for every result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    run_best_sq = '1; run_best_x = '0; run_best_y = '0; run_have = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 26; recv_stall_pct = 70;
    test_directed();
    test_random(140);
    send_idle_pct = 70; recv_stall_pct = 26;
    test_random(140);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(150);
    drain();
    $display("Covered %0d edges, %0d polygon distances checked, %0d mismatches.",
             edges_sent, polygons_checked, errors);
    if (errors == 0 && distance_q.size() == 0)
      $display("point_polygon_nearest_distance verification clean");
    else
      $display("point_polygon_nearest_distance verification failed");
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #20ms;
    $display("point_polygon_nearest_distance verification failed");
    $finish;
  end
endmodule
